// ===== sv/tlbtp_pkg.sv =====
// Shared constants and types for the two-level page translation block.
// Depends on nothing; imported by tlb_two_level_page_translate.
package tlbtp_pkg;

   localparam int BUFFER_ENTRIES_DEF   = 16;
   localparam int OUTER_INDEX_BITS_DEF = 10;
   localparam int INNER_INDEX_BITS_DEF = 10;

   localparam int PAGE_OFFSET_BITS = 12;
   localparam int VIRT_ADDR_BITS   = 32;
   localparam int FRAME_BITS       = 21;
   localparam int PHYS_ADDR_BITS   = FRAME_BITS + PAGE_OFFSET_BITS;
   localparam int COUNT_BITS       = 32;
   localparam int FIRST_FRAME_BITS = 10;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [FIRST_FRAME_BITS-1:0] FIRST_FRAME_RESET = FIRST_FRAME_BITS'(10);

   // Register index, taken from paddr[2]
   localparam logic REG_FIRST_FRAME = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WALK
   } state_type;

endpackage

// ===== sv/tlb_two_level_page_translate.sv =====
// Two-level page translation with a FIFO-replaced translation buffer; uses tlbtp_pkg.
// A hit in buffer slot k strobes its result once slots 0 to k are scanned; a miss once all
// BUFFER_ENTRIES slots are scanned and the frame table is read (one shared comparator scans one
// slot a cycle). A new item is taken only after the last is strobed; start is taken again in the strobe cycle.
// Reset: synchronous; the frame table is then cleared one entry a cycle, covering all
// 2^(OUTER+INNER index bits) entries (1,048,576 by default) with busy high. No result stall.
module tlb_two_level_page_translate
   import tlbtp_pkg::*;
#(
   parameter int BUFFER_ENTRIES   = BUFFER_ENTRIES_DEF,
   parameter int OUTER_INDEX_BITS = OUTER_INDEX_BITS_DEF,
   parameter int INNER_INDEX_BITS = INNER_INDEX_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // item input
   input  logic                        start,
   output logic                        busy,
   input  logic [VIRT_ADDR_BITS-1:0]   req_virt_addr,
   // result output
   output logic                        rsp_strobe,
   output logic [PHYS_ADDR_BITS-1:0]   rsp_phys_addr,
   output logic [FRAME_BITS-1:0]       rsp_frame_no,
   output logic                        rsp_tlb_hit,
   output logic [COUNT_BITS-1:0]       rsp_hit_total,
   output logic [COUNT_BITS-1:0]       rsp_miss_total,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_BITS-1:0]    paddr,
   input  logic [CSR_DATA_BITS-1:0]    pwdata,
   output logic [CSR_DATA_BITS-1:0]    prdata,
   output logic                        pready
);

   localparam int PAGE_BITS = OUTER_INDEX_BITS + INNER_INDEX_BITS;
   localparam int TABLE_DEPTH = 1 << PAGE_BITS;
   localparam int SLOT_BITS = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(BUFFER_ENTRIES - 1);
   localparam logic [PAGE_BITS-1:0] LAST_PAGE = {PAGE_BITS{1'b1}};

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type                    state_ff, state_in;
   logic [PAGE_BITS-1:0]         page_ff, page_in;
   logic [PAGE_OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [SLOT_BITS-1:0]         scan_idx_ff, scan_idx_in;
   logic [SLOT_BITS-1:0]         fifo_slot_ff, fifo_slot_in;
   logic [PAGE_BITS-1:0]         clear_addr_ff, clear_addr_in;
   logic [COUNT_BITS-1:0]        hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0]        miss_cnt_ff, miss_cnt_in;
   logic [FRAME_BITS-1:0]        next_free_ff, next_free_in;
   logic [FIRST_FRAME_BITS-1:0]  first_frame_ff, first_frame_in;

   // translation buffer: valid bits reset, page/frame payload written before use
   logic [BUFFER_ENTRIES-1:0]    buf_valid_ff;
   logic [PAGE_BITS-1:0]         buf_page_ff  [BUFFER_ENTRIES];
   logic [FRAME_BITS-1:0]        buf_frame_ff [BUFFER_ENTRIES];
   logic                         buf_we;

   // frame table memory, one write port, one registered read port
   logic [FRAME_BITS-1:0]        frame_mem [TABLE_DEPTH];
   logic [FRAME_BITS-1:0]        rd_data_ff;
   logic                         mem_we;
   logic [PAGE_BITS-1:0]         mem_waddr;
   logic [FRAME_BITS-1:0]        mem_wdata;

   // result registers
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [FRAME_BITS-1:0]        rsp_frame_ff, rsp_frame_in;
   logic [PAGE_OFFSET_BITS-1:0]  rsp_offset_ff;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic                         rsp_load;

   logic                         csr_write;
   logic                         slot_match;
   logic [FRAME_BITS-1:0]        walk_frame;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_FRAME);
   assign prdata    = (paddr[2] == REG_FIRST_FRAME)
                      ? CSR_DATA_BITS'(first_frame_ff) : '0;

   // ---------------------------------------------------------------------
   // Shared comparator: one buffer slot per cycle
   // ---------------------------------------------------------------------
   assign slot_match = buf_valid_ff[scan_idx_ff] && (buf_page_ff[scan_idx_ff] == page_ff);

   // table entry zero means unmapped: hand out the next free frame
   assign walk_frame = (rd_data_ff == '0) ? next_free_ff : rd_data_ff;

   assign busy = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      scan_idx_in    = scan_idx_ff;
      fifo_slot_in   = fifo_slot_ff;
      clear_addr_in  = clear_addr_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      next_free_in   = next_free_ff;
      first_frame_in = first_frame_ff;
      buf_we         = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = page_ff;
      mem_wdata      = next_free_ff;
      rsp_strobe_in  = 1'b0;
      rsp_frame_in   = rsp_frame_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_load       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the frame table back to unmapped
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            mem_wdata     = '0;
            clear_addr_in = clear_addr_ff + PAGE_BITS'(1);
            if (clear_addr_ff == LAST_PAGE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               page_in     = req_virt_addr[PAGE_OFFSET_BITS +: PAGE_BITS];
               offset_in   = req_virt_addr[PAGE_OFFSET_BITS-1:0];
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_match) begin
               hit_cnt_in    = hit_cnt_ff + COUNT_BITS'(1);
               rsp_frame_in  = buf_frame_ff[scan_idx_ff];
               rsp_hit_in    = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_load      = 1'b1;
               state_in      = ST_IDLE;
            end else if (scan_idx_ff == LAST_SLOT) begin
               state_in = ST_WALK;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
            end
         end
         ST_WALK: begin
            // table data for page_ff is valid here
            miss_cnt_in = miss_cnt_ff + COUNT_BITS'(1);
            if (rd_data_ff == '0) begin
               mem_we       = 1'b1;
               next_free_in = next_free_ff + FRAME_BITS'(1);
            end
            buf_we        = 1'b1;
            fifo_slot_in  = (fifo_slot_ff == LAST_SLOT) ? '0 : fifo_slot_ff + SLOT_BITS'(1);
            rsp_frame_in  = walk_frame;
            rsp_hit_in    = 1'b0;
            rsp_strobe_in = 1'b1;
            rsp_load      = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes are expected only while idle; reload the free frame counter
      if (csr_write) begin
         first_frame_in = pwdata[FIRST_FRAME_BITS-1:0];
         next_free_in   = FRAME_BITS'(pwdata[FIRST_FRAME_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_addr_ff  <= '0;
         scan_idx_ff    <= '0;
         fifo_slot_ff   <= '0;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         first_frame_ff <= FIRST_FRAME_RESET;
         next_free_ff   <= FRAME_BITS'(FIRST_FRAME_RESET);
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         scan_idx_ff    <= scan_idx_in;
         fifo_slot_ff   <= fifo_slot_in;
         hit_cnt_ff     <= hit_cnt_in;
         miss_cnt_ff    <= miss_cnt_in;
         first_frame_ff <= first_frame_in;
         next_free_ff   <= next_free_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // item payload and result payload, no reset needed
   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      offset_ff    <= offset_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_hit_ff   <= rsp_hit_in;
      if (rsp_load) begin
         rsp_offset_ff <= offset_ff;
      end
   end

   // buffer valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= '0;
      end else if (buf_we) begin
         buf_valid_ff[fifo_slot_ff] <= 1'b1;
      end
   end

   // buffer payload, written at the FIFO slot on a miss
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_page_ff[fifo_slot_ff]  <= page_ff;
         buf_frame_ff[fifo_slot_ff] <= walk_frame;
      end
   end

   // frame table write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
   end

   // frame table read port: follow the current page every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= frame_mem[page_ff];
   end

   // ---------------------------------------------------------------------
   // Result ports; counters already include this item
   // ---------------------------------------------------------------------
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_frame_no     = rsp_frame_ff;
   assign rsp_phys_addr    = {rsp_frame_ff, rsp_offset_ff};
   assign rsp_tlb_hit      = rsp_hit_ff;
   assign rsp_hit_total    = hit_cnt_ff;
   assign rsp_miss_total   = miss_cnt_ff;

`ifndef ASSERT_OFF
   // a result is shown only once the sequencer is back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // every item passes through the scan state, so strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back result strobes");

   // a table walk always ends in a miss result
   a_walk_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |=> (rsp_strobe && !rsp_tlb_hit))
      else $error("table walk without a miss result");

   // reset starts the frame table clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && busy))
      else $error("reset did not start the clearing pass");
`endif

endmodule
